// ===== rtl/kmd_pkg.sv =====
// Shared types and constants of the key matrix debouncer.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package kmd_pkg;

    localparam int COL_FIELD_W  = 2;
    localparam int ROW_FIELD_W  = 4;
    localparam int KEY_W        = 4;
    localparam int CNT_W        = 8;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 8;
    localparam logic [CNT_W-1:0] THRESH_RESET = 8'd10;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic hit;
        logic released;
    } kmd_evt_t;

endpackage

`default_nettype wire

// ===== rtl/key_matrix_debouncer.sv =====
// Top level of the key matrix debouncer: row lanes, merging stage, threshold register.
// Depends on kmd_pkg, kmd_lane and kmd_merge.
`default_nettype none

// Each accepted beat carries one scanned column and its active-low row levels. Every
// row lane updates the debounce counter of its key in the same cycle, so a new sample
// is taken every cycle if the last one produced at most one event and the receiver is
// ready. A sample with several events holds the input until its last event enters the
// single output register, which sends one event per beat; while the receiver stalls,
// one further sample can wait behind that register. Counters live in flip-flops and
// are cleared by reset; no clearing pass is needed. Columns at or beyond NUM_COLUMNS
// are ignored, and only the lowest rows up to the four-bit row field are sampled.
module key_matrix_debouncer #(
    parameter int NUM_ROWS    = 4,
    parameter int NUM_COLUMNS = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] column_index, [5:2] row_levels, [7:6] zero
    input  wire logic [kmd_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] key_index, [7:4] zero
    output logic [kmd_pkg::OUT_DATA_W-1:0]       m_tdata,
    // [0] key_released
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kmd_pkg::CNT_W-1:0]       cfg_data
);

    localparam int LANES     = (NUM_ROWS < kmd_pkg::ROW_FIELD_W) ? NUM_ROWS
                                                                 : kmd_pkg::ROW_FIELD_W;
    localparam int COL_DEPTH = (NUM_COLUMNS < 4) ? NUM_COLUMNS : 4;

    kmd_pkg::cnt_t                   thresh_reg;
    logic [kmd_pkg::COL_FIELD_W-1:0] col;
    logic [kmd_pkg::ROW_FIELD_W-1:0] levels;
    logic                            accept;
    logic                            col_ok;
    logic                            lane_en;
    kmd_pkg::kmd_evt_t               evt [LANES];

    assign col       = s_tdata[kmd_pkg::COL_FIELD_W-1:0];
    assign levels    = s_tdata[kmd_pkg::COL_FIELD_W +: kmd_pkg::ROW_FIELD_W];
    assign accept    = s_tvalid && s_tready;
    assign col_ok    = (32'(col) < NUM_COLUMNS);
    assign lane_en   = accept && col_ok;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= kmd_pkg::THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thresh_reg <= cfg_data;
        end
    end

    for (genvar r = 0; r < LANES; r++) begin : g_lane
        kmd_lane #(
            .COL_DEPTH(COL_DEPTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .enable    (lane_en),
            .col       (col),
            .level     (levels[r]),
            .threshold (thresh_reg),
            .evt       (evt[r])
        );
    end

    kmd_merge #(
        .LANES    (LANES),
        .NUM_ROWS (NUM_ROWS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .col      (col),
        .evt      (evt),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/kmd_lane.sv =====
// One row lane: a bank of integrating debounce counters, one per column.
// Depends on kmd_pkg.
`default_nettype none

module kmd_lane #(
    parameter int COL_DEPTH = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           enable,
    input  wire logic [kmd_pkg::COL_FIELD_W-1:0] col,
    input  wire logic                           level,
    input  wire kmd_pkg::cnt_t                  threshold,
    output kmd_pkg::kmd_evt_t                   evt
);

    localparam int IDX_W = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;

    kmd_pkg::cnt_t   cnt_reg [COL_DEPTH];
    kmd_pkg::cnt_t   cnt_cur;
    kmd_pkg::cnt_t   cnt_new;
    logic [IDX_W-1:0] idx;
    logic            change;

    assign idx     = col[IDX_W-1:0];
    assign cnt_cur = cnt_reg[idx];

    always_comb begin
        cnt_new      = cnt_cur;
        change       = 1'b0;
        evt.hit      = 1'b0;
        evt.released = 1'b0;
        if (!level) begin
            if (cnt_cur < threshold) begin
                cnt_new = cnt_cur + kmd_pkg::cnt_t'(1);
                change  = 1'b1;
                evt.hit = enable && (cnt_new == threshold);
            end
        end else begin
            if (cnt_cur != '0) begin
                cnt_new      = cnt_cur - kmd_pkg::cnt_t'(1);
                change       = 1'b1;
                evt.hit      = enable && (cnt_new == '0);
                evt.released = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COL_DEPTH; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (enable && change) begin
            cnt_reg[idx] <= cnt_new;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmd_merge.sv =====
// Merging stage: holds the lane events of one sample and sends them out one beat
// at a time in ascending row order through an output register. Depends on kmd_pkg.
`default_nettype none

module kmd_merge #(
    parameter int LANES    = 4,
    parameter int NUM_ROWS = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire logic [kmd_pkg::COL_FIELD_W-1:0] col,
    input  wire kmd_pkg::kmd_evt_t               evt [LANES],
    output logic                                 in_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kmd_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int ROW_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANES-1:0]                mask_reg, mask_next, mask_after, onehot;
    logic [LANES-1:0]                rel_reg, rel_next;
    logic [kmd_pkg::COL_FIELD_W-1:0] col_reg, col_next;
    logic                            valid_reg, valid_next;
    logic [kmd_pkg::KEY_W-1:0]       key_reg, key_next;
    logic                            relo_reg, relo_next;
    logic                            last_reg, last_next;
    logic [ROW_IDX_W-1:0]            sel_row;
    logic [7:0]                      key_full;
    logic                            out_load;

    always_comb begin
        sel_row = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_row = ROW_IDX_W'(i);
            end
        end
    end

    assign onehot   = LANES'(1) << sel_row;
    assign key_full = 8'(col_reg) * 8'(NUM_ROWS) + 8'(sel_row);
    assign out_load = !valid_reg || m_tready;

    always_comb begin
        mask_after = mask_reg;
        valid_next = valid_reg;
        key_next   = key_reg;
        relo_next  = relo_reg;
        last_next  = last_reg;
        if (out_load) begin
            if (mask_reg != '0) begin
                mask_after = mask_reg & ~onehot;
                valid_next = 1'b1;
                key_next   = key_full[kmd_pkg::KEY_W-1:0];
                relo_next  = rel_reg[sel_row];
                last_next  = ((mask_reg & ~onehot) == '0);
            end else begin
                valid_next = 1'b0;
            end
        end
        in_ready = (mask_after == '0);
        mask_next = mask_after;
        rel_next  = rel_reg;
        col_next  = col_reg;
        if (load) begin
            for (int i = 0; i < LANES; i++) begin
                mask_next[i] = evt[i].hit;
                rel_next[i]  = evt[i].released;
            end
            col_next = col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
        rel_reg  <= rel_next;
        col_reg  <= col_next;
        key_reg  <= key_next;
        relo_reg <= relo_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = kmd_pkg::OUT_DATA_W'(key_reg);
    assign m_tuser  = relo_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/kmd_checker.sv =====
// Port-level checks of the key matrix debouncer, attached to the top level by bind.
// Depends on kmd_pkg and key_matrix_debouncer.
`default_nettype none

module kmd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [kmd_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("Stalled output beat changed.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && !m_tready |-> !s_tready)
        else $error("Input taken while events of a sample were still pending.");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("Gap inside the events of one sample.");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for key_matrix_debouncer: drives column scans over the stream
// input, predicts key-down and key-up events per beat, and checks every output beat.
// Depends on kmd_pkg and rtl/key_matrix_debouncer.sv.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS          = 4;
    localparam int COLS          = 4;
    localparam int KEYS          = ROWS * COLS;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [kmd_pkg::COL_FIELD_W-1:0] col;
        logic [kmd_pkg::ROW_FIELD_W-1:0] levels;
    } scan_t;

    typedef struct {
        logic [kmd_pkg::KEY_W-1:0] key;
        logic                      released;
        logic                      last;
    } key_event_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [kmd_pkg::IN_DATA_W-1:0]     s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [kmd_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [kmd_pkg::CNT_W-1:0]         cfg_data = '0;

    scan_t          scan_queue[$];
    key_event_t     pending_events[$];
    kmd_pkg::cnt_t  key_cnt[KEYS];
    kmd_pkg::cnt_t  threshold = kmd_pkg::THRESH_RESET;
    int             items_total = 0;
    int             items_taken = 0;
    int             errors = 0;
    int             sender_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_left = 0;
    int             cycle_count = 0;

    key_matrix_debouncer #(
        .NUM_ROWS    (ROWS),
        .NUM_COLUMNS (COLS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void debounce_sample(input logic [1:0] col, input logic [3:0] levels);
        key_event_t evs[$];
        key_event_t ev;
        int         key;
        if (col >= COLS) return;
        for (int r = 0; r < ROWS && r < kmd_pkg::ROW_FIELD_W; r++) begin
            key = col * ROWS + r;
            if (key >= KEYS) break;
            ev.key = key[kmd_pkg::KEY_W-1:0];
            ev.last = 1'b0;
            if (!levels[r]) begin
                if (key_cnt[key] < threshold) begin
                    key_cnt[key] = key_cnt[key] + 1'b1;
                    if (key_cnt[key] == threshold) begin
                        ev.released = 1'b0;
                        evs.push_back(ev);
                    end
                end
            end else if (key_cnt[key] != 0) begin
                key_cnt[key] = key_cnt[key] - 1'b1;
                if (key_cnt[key] == 0) begin
                    ev.released = 1'b1;
                    evs.push_back(ev);
                end
            end
        end
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
        foreach (evs[i]) pending_events.push_back(evs[i]);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                debounce_sample(s_tdata[1:0], s_tdata[5:2]);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (scan_queue.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    scan_t item;
                    item = scan_queue.pop_front();
                    s_tdata  <= {2'b00, item.levels, item.col};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        key_event_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat key %0d released %0b last %0b",
                                              m_tdata, m_tuser, m_tlast));
                end else begin
                    want = pending_events.pop_front();
                    if (m_tdata !== {4'b0000, want.key} || m_tuser !== want.released ||
                        m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "got key %0d released %0b last %0b, want key %0d released %0b last %0b",
                            m_tdata, m_tuser, m_tlast, want.key, want.released, want.last));
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic push_scan(input logic [1:0] col, input logic [3:0] levels);
        scan_t item;
        item.col = col;
        item.levels = levels;
        scan_queue.push_back(item);
        items_total++;
    endtask

    task automatic push_bursts(input int count);
        int          pushed;
        int          reps;
        logic [1:0]  col;
        logic [3:0]  pat;
        logic [3:0]  lv;
        pushed = 0;
        while (pushed < count) begin
            col = 2'($urandom_range(COLS - 1, 0));
            pat = 4'($urandom_range(15, 0));
            if ($urandom_range(99, 0) < 15) begin
                push_scan(col, pat);
                pushed++;
            end else begin
                reps = $urandom_range(threshold + 2, 1);
                for (int i = 0; i < reps; i++) begin
                    lv = pat;
                    if ($urandom_range(99, 0) < 15) lv[2'($urandom_range(3, 0))] = ~lv[0];
                    if ($urandom_range(99, 0) < 10) lv = ~pat;
                    push_scan(col, lv);
                    pushed++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (items_taken != items_total || pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_threshold(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        threshold = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic begin_phase(input int send_idle, input int recv_stall);
        @(posedge aclk);
        sender_idle_pct <= send_idle;
        recv_stall_pct  <= recv_stall;
    endtask

    initial begin
        for (int k = 0; k < KEYS; k++) key_cnt[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset threshold: a full press on column 0, an idle scan, a partial pattern.
        begin_phase(0, 0);
        repeat (10) push_scan(2'd0, 4'h0);
        push_scan(2'd3, 4'hF);
        push_scan(2'd1, 4'b1010);
        push_scan(2'd1, 4'b1010);
        wait_idle();

        // Threshold 1 with column 0 counters left above it.
        load_threshold(8'd1);
        push_scan(2'd0, 4'h0);
        push_scan(2'd0, 4'hF);
        push_scan(2'd2, 4'b0101);
        push_scan(2'd2, 4'hF);
        push_scan(2'd3, 4'h0);
        push_scan(2'd3, 4'hF);
        push_scan(2'd1, 4'hF);
        wait_idle();

        // Long receiver hold-off so the block backs up and stalls its input.
        begin_phase(0, 0);
        @(posedge aclk);
        hold_left <= HOLD_CYCLES;
        push_bursts(20);
        wait_idle();
        push_bursts(20);
        wait_idle();

        load_threshold(8'd3);
        begin_phase(62, 0);
        push_bursts(35);
        wait_idle();

        load_threshold(8'd0);
        begin_phase(0, 62);
        push_bursts(30);
        wait_idle();

        load_threshold(8'd5);
        begin_phase(32, 32);
        push_bursts(35);
        wait_idle();

        load_threshold(8'd12);
        begin_phase(0, 0);
        repeat (13) push_scan(2'd1, 4'h0);
        repeat (12) push_scan(2'd1, 4'hF);
        wait_idle();

        load_threshold(8'd2);
        begin_phase(32, 32);
        push_bursts(30);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
        if (errors == 0) begin
            $display("[key_matrix_debouncer] OK");
        end else begin
            $display("[key_matrix_debouncer] ERROR");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[key_matrix_debouncer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/kmd_pkg.sv
rtl/kmd_lane.sv
rtl/kmd_merge.sv
rtl/key_matrix_debouncer.sv
rtl/kmd_checker.sv
bench/testbench.sv
